FILE: src/tced_pkg.sv
`default_nettype none

package tced_pkg;

    localparam int FIELD_W     = 16;
    localparam int CAR_FLOOR_W = 4;
    localparam int TICK_W      = 8;

    localparam logic [TICK_W-1:0] TRAVEL_TICKS_RESET = 8'd3;

    localparam int SLOT_COUNT = 3;

    // Scan passes: calls ahead in the travel direction, any call from the far end,
    // and calls behind the car in the travel direction.
    localparam logic [1:0] SLOT_AHEAD  = 2'd0;
    localparam logic [1:0] SLOT_ANY    = 2'd1;
    localparam logic [1:0] SLOT_BEHIND = 2'd2;

    typedef struct packed {
        logic [FIELD_W-1:0] hall_up_press;
        logic [FIELD_W-1:0] hall_down_press;
        logic [FIELD_W-1:0] car_a_press;
        logic [FIELD_W-1:0] car_b_press;
    } t_req;

    typedef struct packed {
        logic [CAR_FLOOR_W-1:0] car_a_floor;
        logic                   car_a_up;
        logic [CAR_FLOOR_W-1:0] car_a_target;
        logic                   car_a_arrived;
        logic [CAR_FLOOR_W-1:0] car_b_floor;
        logic                   car_b_up;
        logic [CAR_FLOOR_W-1:0] car_b_target;
        logic                   car_b_arrived;
        logic [FIELD_W-1:0]     hall_up_pending;
        logic [FIELD_W-1:0]     hall_down_pending;
    } t_rsp;

    typedef struct packed {
        logic hall_up;
        logic hall_down;
        logic car_a;
        logic car_b;
    } t_calls;

    typedef struct packed {
        logic going_up;
        logic sel_b;
        logic claim_en;
        logic skip_set;
        logic skip_one;
    } t_ctx;

    typedef struct packed {
        logic                  valid;
        logic [SLOT_COUNT-1:0] hit;
    } t_wave;

    typedef struct packed {
        logic en;
        logic a_arrived;
        logic a_up;
        logic b_arrived;
        logic b_up;
    } t_serve;

endpackage

`default_nettype wire

FILE: src/tced_cell.sv
`default_nettype none

module tced_cell #(
    parameter int FLOORS = 16,
    parameter int INDEX  = 0
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_load,
    input  wire tced_pkg::t_calls                               i_press,
    input  wire tced_pkg::t_ctx                                 i_ctx,
    input  wire logic [$clog2(FLOORS)-1:0]                      i_ctx_floor,
    input  wire logic [$clog2(FLOORS)-1:0]                      i_skip_idx,
    input  wire tced_pkg::t_serve                               i_serve,
    input  wire logic [$clog2(FLOORS)-1:0]                      i_serve_a_floor,
    input  wire logic [$clog2(FLOORS)-1:0]                      i_serve_b_floor,
    input  wire tced_pkg::t_wave                                i_asc,
    input  wire logic [tced_pkg::SLOT_COUNT-1:0][$clog2(FLOORS)-1:0] i_asc_idx,
    output tced_pkg::t_wave                                     o_asc,
    output logic [tced_pkg::SLOT_COUNT-1:0][$clog2(FLOORS)-1:0] o_asc_idx,
    input  wire tced_pkg::t_wave                                i_dsc,
    input  wire logic [tced_pkg::SLOT_COUNT-1:0][$clog2(FLOORS)-1:0] i_dsc_idx,
    output tced_pkg::t_wave                                     o_dsc,
    output logic [tced_pkg::SLOT_COUNT-1:0][$clog2(FLOORS)-1:0] o_dsc_idx,
    output tced_pkg::t_calls                                    o_calls
);

    localparam int FW = $clog2(FLOORS);
    localparam logic [FW-1:0] INDEX_FW = FW'(INDEX);
    localparam logic IS_BOTTOM = (INDEX == 0);
    localparam logic IS_TOP    = (INDEX == FLOORS - 1);

    tced_pkg::t_calls r_calls, n_calls;
    tced_pkg::t_wave  r_asc, n_asc, r_dsc, n_dsc;
    logic [tced_pkg::SLOT_COUNT-1:0][FW-1:0] r_asc_idx, n_asc_idx, r_dsc_idx, n_dsc_idx;
    logic r_claim;

    logic cc, skip, up_eff, dn_eff, above, below, away, a_here, b_here;
    logic [tced_pkg::SLOT_COUNT-1:0] asc_m, dsc_m;

    always_comb begin
        cc     = i_ctx.sel_b ? r_calls.car_b : r_calls.car_a;
        skip   = i_ctx.skip_set ? r_claim : (i_ctx.skip_one && (i_skip_idx == INDEX_FW));
        up_eff = r_calls.hall_up & ~skip;
        dn_eff = r_calls.hall_down & ~skip;
        above  = INDEX_FW > i_ctx_floor;
        below  = INDEX_FW < i_ctx_floor;
        away   = INDEX_FW != i_ctx_floor;

        asc_m[tced_pkg::SLOT_AHEAD]  = i_ctx.going_up & above & (cc | up_eff);
        asc_m[tced_pkg::SLOT_ANY]    = ~i_ctx.going_up & away & (cc | up_eff);
        asc_m[tced_pkg::SLOT_BEHIND] = i_ctx.going_up & below & up_eff;
        dsc_m[tced_pkg::SLOT_AHEAD]  = ~i_ctx.going_up & below & (cc | dn_eff);
        dsc_m[tced_pkg::SLOT_ANY]    = i_ctx.going_up & away & (cc | dn_eff);
        dsc_m[tced_pkg::SLOT_BEHIND] = ~i_ctx.going_up & above & dn_eff;
    end

    always_comb begin
        n_asc.valid = i_asc.valid;
        n_asc.hit   = i_asc.hit | asc_m;
        n_dsc.valid = i_dsc.valid;
        n_dsc.hit   = i_dsc.hit | dsc_m;

        n_asc_idx[tced_pkg::SLOT_AHEAD]  = i_asc.hit[tced_pkg::SLOT_AHEAD] ?
                                           i_asc_idx[tced_pkg::SLOT_AHEAD] : INDEX_FW;
        n_asc_idx[tced_pkg::SLOT_ANY]    = i_asc.hit[tced_pkg::SLOT_ANY] ?
                                           i_asc_idx[tced_pkg::SLOT_ANY] : INDEX_FW;
        n_asc_idx[tced_pkg::SLOT_BEHIND] = i_asc.hit[tced_pkg::SLOT_BEHIND] ?
                                           i_asc_idx[tced_pkg::SLOT_BEHIND] : INDEX_FW;
        n_dsc_idx[tced_pkg::SLOT_AHEAD]  = i_dsc.hit[tced_pkg::SLOT_AHEAD] ?
                                           i_dsc_idx[tced_pkg::SLOT_AHEAD] : INDEX_FW;
        n_dsc_idx[tced_pkg::SLOT_ANY]    = i_dsc.hit[tced_pkg::SLOT_ANY] ?
                                           i_dsc_idx[tced_pkg::SLOT_ANY] : INDEX_FW;
        n_dsc_idx[tced_pkg::SLOT_BEHIND] = i_dsc.hit[tced_pkg::SLOT_BEHIND] ?
                                           i_dsc_idx[tced_pkg::SLOT_BEHIND] : INDEX_FW;
    end

    always_comb begin
        a_here  = i_serve.a_arrived && (i_serve_a_floor == INDEX_FW);
        b_here  = i_serve.b_arrived && (i_serve_b_floor == INDEX_FW);
        n_calls = r_calls;
        if (i_load) begin
            n_calls.hall_up   = r_calls.hall_up | i_press.hall_up;
            n_calls.hall_down = r_calls.hall_down | i_press.hall_down;
            n_calls.car_a     = r_calls.car_a | i_press.car_a;
            n_calls.car_b     = r_calls.car_b | i_press.car_b;
        end else if (i_serve.en) begin
            if (a_here) begin
                n_calls.car_a = 1'b0;
                if (i_serve.a_up || IS_BOTTOM) begin
                    n_calls.hall_up = 1'b0;
                end
                if (!i_serve.a_up || IS_TOP) begin
                    n_calls.hall_down = 1'b0;
                end
            end
            if (b_here) begin
                n_calls.car_b = 1'b0;
                if (i_serve.b_up || IS_BOTTOM) begin
                    n_calls.hall_up = 1'b0;
                end
                if (!i_serve.b_up || IS_TOP) begin
                    n_calls.hall_down = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calls     <= '0;
            r_asc.valid <= 1'b0;
            r_dsc.valid <= 1'b0;
        end else begin
            r_calls <= n_calls;
            r_asc   <= n_asc;
            r_dsc   <= n_dsc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_asc_idx <= n_asc_idx;
        r_dsc_idx <= n_dsc_idx;
        if (i_ctx.claim_en) begin
            r_claim <= asc_m[tced_pkg::SLOT_AHEAD] | dsc_m[tced_pkg::SLOT_AHEAD];
        end
    end

    assign o_asc     = r_asc;
    assign o_asc_idx = r_asc_idx;
    assign o_dsc     = r_dsc;
    assign o_dsc_idx = r_dsc_idx;
    assign o_calls   = r_calls;

endmodule

`default_nettype wire

FILE: src/tced_car.sv
`default_nettype none

module tced_car #(
    parameter int FLOORS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_apply,
    input  wire logic [$clog2(FLOORS)-1:0]     i_apply_target,
    input  wire logic                          i_apply_up,
    input  wire logic                          i_advance,
    input  wire logic [tced_pkg::TICK_W-1:0]   i_travel_ticks,
    output logic      [$clog2(FLOORS)-1:0]     o_floor,
    output logic                               o_up,
    output logic      [$clog2(FLOORS)-1:0]     o_target,
    output logic                               o_arrived
);

    localparam int FW = $clog2(FLOORS);
    localparam logic [FW-1:0] LAST = FW'(FLOORS - 1);

    logic [FW-1:0] r_floor, n_floor, r_target, n_target, step_floor;
    logic r_up, n_up, step_up, r_arrived, n_arrived, due;
    logic [tced_pkg::TICK_W-1:0] r_count, n_count;

    always_comb begin
        due        = r_count == i_travel_ticks;
        step_floor = r_floor;
        step_up    = r_up;
        if (r_target > r_floor) begin
            step_floor = r_floor + 1'b1;
            if (step_floor == LAST) begin
                step_up = 1'b0;
            end
        end else if (r_target < r_floor) begin
            step_floor = r_floor - 1'b1;
            if (step_floor == '0) begin
                step_up = 1'b1;
            end
        end
    end

    always_comb begin
        n_floor   = r_floor;
        n_up      = r_up;
        n_target  = r_target;
        n_count   = r_count;
        n_arrived = r_arrived;
        if (i_apply) begin
            n_target = i_apply_target;
            n_up     = i_apply_up;
        end else if (i_advance) begin
            if (due) begin
                n_floor   = step_floor;
                n_up      = step_up;
                n_arrived = step_floor == r_target;
                n_count   = tced_pkg::TICK_W'(1);
            end else begin
                n_arrived = 1'b0;
                n_count   = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor   <= '0;
            r_up      <= 1'b1;
            r_target  <= '0;
            r_count   <= '0;
            r_arrived <= 1'b0;
        end else begin
            r_floor   <= n_floor;
            r_up      <= n_up;
            r_target  <= n_target;
            r_count   <= n_count;
            r_arrived <= n_arrived;
        end
    end

    assign o_floor   = r_floor;
    assign o_up      = r_up;
    assign o_target  = r_target;
    assign o_arrived = r_arrived;

endmodule

`default_nettype wire

FILE: src/two_car_elevator_dispatch.sv
// Each request runs two scan waves (car A, then car B) that each cross the chain of floor cells one cell per cycle.
// A second request is buffered while the current one is in work.
// Reset (synchronous, active low) clears all calls, puts both cars on floor 0 going up
// with target 0 and counter 0, and sets travel_ticks to 3.
`default_nettype none

module two_car_elevator_dispatch #(
    parameter int FLOORS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire tced_pkg::t_req              i_in_req,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output tced_pkg::t_rsp                   o_out_rsp,
    input  wire logic                        i_cfg_we,
    input  wire logic [tced_pkg::TICK_W-1:0] i_cfg_wdata
);

    localparam int FW          = $clog2(FLOORS);
    localparam int FIELD_W     = tced_pkg::FIELD_W;
    localparam int CAR_FLOOR_W = tced_pkg::CAR_FLOOR_W;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LOAD   = 9'b000000010,
        S_SCAN_A = 9'b000000100,
        S_WAIT_A = 9'b000001000,
        S_SCAN_B = 9'b000010000,
        S_WAIT_B = 9'b000100000,
        S_MOVE   = 9'b001000000,
        S_CLEAR  = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic                        r_req_valid;
    tced_pkg::t_req              r_req;
    logic [tced_pkg::TICK_W-1:0] r_travel_ticks;
    logic                        r_out_valid;
    tced_pkg::t_rsp              r_out;
    logic                        r_skip_set, r_skip_one;
    logic [FW-1:0]               r_skip_idx;

    tced_pkg::t_wave                         w_asc [0:FLOORS];
    logic [tced_pkg::SLOT_COUNT-1:0][FW-1:0] w_asc_idx [0:FLOORS];
    tced_pkg::t_wave                         w_dsc [0:FLOORS];
    logic [tced_pkg::SLOT_COUNT-1:0][FW-1:0] w_dsc_idx [0:FLOORS];
    tced_pkg::t_calls                        w_calls [0:FLOORS-1];
    tced_pkg::t_calls                        w_press [0:FLOORS-1];
    logic [FLOORS-1:0]                       hall_up_vec, hall_dn_vec;

    tced_pkg::t_ctx   ctx;
    tced_pkg::t_serve serve;

    logic [FW-1:0] a_floor, a_target, b_floor, b_target, cur_floor, pick_target;
    logic          a_up, a_arrived, b_up, b_arrived, cur_up, pick_up;
    logic          scan_b, inject, done, got, apply_a, apply_b, out_free;
    logic [tced_pkg::SLOT_COUNT-1:0]         hit;
    logic [tced_pkg::SLOT_COUNT-1:0][FW-1:0] slot_idx;

    assign o_in_stall = r_req_valid;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign scan_b     = (r_state == S_SCAN_B) || (r_state == S_WAIT_B);
    assign inject     = (r_state == S_SCAN_A) || (r_state == S_SCAN_B);
    assign cur_floor  = scan_b ? b_floor : a_floor;
    assign cur_up     = scan_b ? b_up : a_up;

    assign w_asc[0]          = '{valid: inject, hit: '0};
    assign w_asc_idx[0]      = '0;
    assign w_dsc[FLOORS]     = '{valid: inject, hit: '0};
    assign w_dsc_idx[FLOORS] = '0;

    assign ctx.going_up = cur_up;
    assign ctx.sel_b    = scan_b;
    assign ctx.claim_en = (r_state == S_SCAN_A) || (r_state == S_WAIT_A);
    assign ctx.skip_set = scan_b && r_skip_set;
    assign ctx.skip_one = scan_b && r_skip_one;

    assign serve.en        = r_state == S_CLEAR;
    assign serve.a_arrived = a_arrived;
    assign serve.a_up      = a_up;
    assign serve.b_arrived = b_arrived;
    assign serve.b_up      = b_up;

    for (genvar i = 0; i < FLOORS; i++) begin : g_floor
        if (i < FIELD_W) begin : g_press
            assign w_press[i] = '{hall_up:   r_req.hall_up_press[i],
                                  hall_down: r_req.hall_down_press[i],
                                  car_a:     r_req.car_a_press[i],
                                  car_b:     r_req.car_b_press[i]};
        end else begin : g_nopress
            assign w_press[i] = '0;
        end

        tced_cell #(
            .FLOORS (FLOORS),
            .INDEX  (i)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_load          (r_state == S_LOAD),
            .i_press         (w_press[i]),
            .i_ctx           (ctx),
            .i_ctx_floor     (cur_floor),
            .i_skip_idx      (r_skip_idx),
            .i_serve         (serve),
            .i_serve_a_floor (a_floor),
            .i_serve_b_floor (b_floor),
            .i_asc           (w_asc[i]),
            .i_asc_idx       (w_asc_idx[i]),
            .o_asc           (w_asc[i+1]),
            .o_asc_idx       (w_asc_idx[i+1]),
            .i_dsc           (w_dsc[i+1]),
            .i_dsc_idx       (w_dsc_idx[i+1]),
            .o_dsc           (w_dsc[i]),
            .o_dsc_idx       (w_dsc_idx[i]),
            .o_calls         (w_calls[i])
        );

        assign hall_up_vec[i] = w_calls[i].hall_up;
        assign hall_dn_vec[i] = w_calls[i].hall_down;
    end

    assign done = w_asc[FLOORS].valid;
    assign hit  = w_asc[FLOORS].hit | w_dsc[0].hit;
    assign got  = |hit;

    always_comb begin
        slot_idx[tced_pkg::SLOT_AHEAD]  = w_asc[FLOORS].hit[tced_pkg::SLOT_AHEAD] ?
            w_asc_idx[FLOORS][tced_pkg::SLOT_AHEAD] : w_dsc_idx[0][tced_pkg::SLOT_AHEAD];
        slot_idx[tced_pkg::SLOT_ANY]    = w_asc[FLOORS].hit[tced_pkg::SLOT_ANY] ?
            w_asc_idx[FLOORS][tced_pkg::SLOT_ANY] : w_dsc_idx[0][tced_pkg::SLOT_ANY];
        slot_idx[tced_pkg::SLOT_BEHIND] = w_asc[FLOORS].hit[tced_pkg::SLOT_BEHIND] ?
            w_asc_idx[FLOORS][tced_pkg::SLOT_BEHIND] : w_dsc_idx[0][tced_pkg::SLOT_BEHIND];

        priority if (hit[tced_pkg::SLOT_AHEAD]) begin
            pick_target = slot_idx[tced_pkg::SLOT_AHEAD];
            pick_up     = cur_up;
        end else if (hit[tced_pkg::SLOT_ANY]) begin
            pick_target = slot_idx[tced_pkg::SLOT_ANY];
            pick_up     = slot_idx[tced_pkg::SLOT_ANY] > cur_floor;
        end else begin
            pick_target = slot_idx[tced_pkg::SLOT_BEHIND];
            pick_up     = !cur_up;
        end
    end

    assign apply_a = (r_state == S_WAIT_A) && done && got;
    assign apply_b = (r_state == S_WAIT_B) && done && got;

    tced_car #(
        .FLOORS (FLOORS)
    ) u_car_a (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_apply        (apply_a),
        .i_apply_target (pick_target),
        .i_apply_up     (pick_up),
        .i_advance      (r_state == S_MOVE),
        .i_travel_ticks (r_travel_ticks),
        .o_floor        (a_floor),
        .o_up           (a_up),
        .o_target       (a_target),
        .o_arrived      (a_arrived)
    );

    tced_car #(
        .FLOORS (FLOORS)
    ) u_car_b (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_apply        (apply_b),
        .i_apply_target (pick_target),
        .i_apply_up     (pick_up),
        .i_advance      (r_state == S_MOVE),
        .i_travel_ticks (r_travel_ticks),
        .o_floor        (b_floor),
        .o_up           (b_up),
        .o_target       (b_target),
        .o_arrived      (b_arrived)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (r_req_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD:   n_state = S_SCAN_A;
            S_SCAN_A: n_state = S_WAIT_A;
            S_WAIT_A: begin
                if (done) begin
                    n_state = S_SCAN_B;
                end
            end
            S_SCAN_B: n_state = S_WAIT_B;
            S_WAIT_B: begin
                if (done) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE:   n_state = S_CLEAR;
            S_CLEAR:  n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = r_req_valid ? S_LOAD : S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_req_valid    <= 1'b0;
            r_travel_ticks <= tced_pkg::TRAVEL_TICKS_RESET;
            r_out_valid    <= 1'b0;
            r_skip_set     <= 1'b0;
            r_skip_one     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_in_valid && !o_in_stall) begin
                r_req_valid <= 1'b1;
            end else if (r_state == S_LOAD) begin
                r_req_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_travel_ticks <= i_cfg_wdata;
            end
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == S_WAIT_A) && done) begin
                r_skip_set <= hit[tced_pkg::SLOT_AHEAD];
                r_skip_one <= !hit[tced_pkg::SLOT_AHEAD] && got;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_req <= i_in_req;
        end
        if ((r_state == S_WAIT_A) && done) begin
            r_skip_idx <= pick_target;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out.car_a_floor       <= CAR_FLOOR_W'(a_floor);
            r_out.car_a_up          <= a_up;
            r_out.car_a_target      <= CAR_FLOOR_W'(a_target);
            r_out.car_a_arrived     <= a_arrived;
            r_out.car_b_floor       <= CAR_FLOOR_W'(b_floor);
            r_out.car_b_up          <= b_up;
            r_out.car_b_target      <= CAR_FLOOR_W'(b_target);
            r_out.car_b_arrived     <= b_arrived;
            r_out.hall_up_pending   <= FIELD_W'(hall_up_vec);
            r_out.hall_down_pending <= FIELD_W'(hall_dn_vec);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_asc[FLOORS].valid == w_dsc[0].valid)
        else $error("Upward and downward scan waves did not finish together.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_asc[FLOORS].valid |-> (r_state == S_WAIT_A || r_state == S_WAIT_B))
        else $error("A scan wave finished outside a scan wait state.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |=>
            ((!a_arrived || a_floor == a_target) && (!b_arrived || b_floor == b_target)))
        else $error("A car reported arrival away from its target floor.");

endmodule

`default_nettype wire

FILE: tb/sv/tb_two_car_elevator_dispatch.sv
`timescale 1ns / 100ps

module tb_two_car_elevator_dispatch;

    localparam int FLOORS = 16;
    localparam int SETTLE_CYCLES = 2 * FLOORS + 20;
    localparam int N_PHASES = 6;
    localparam int FIELD_W = tced_pkg::FIELD_W;
    localparam int CAR_FLOOR_W = tced_pkg::CAR_FLOOR_W;
    localparam int TICK_W = tced_pkg::TICK_W;

    localparam int MODE_FREE = 0;
    localparam int MODE_SEND_IDLE = 1;
    localparam int MODE_RECV_STALL = 2;
    localparam int MODE_BOTH = 3;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic o_in_stall;
    tced_pkg::t_req in_req = '0;
    logic o_out_valid;
    logic out_stall = 1'b0;
    tced_pkg::t_rsp o_out_rsp;
    logic cfg_we = 1'b0;
    logic [TICK_W-1:0] cfg_wdata = '0;

    logic req_fire = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;

    tced_pkg::t_req press_q[$];
    tced_pkg::t_rsp status_q[$];

    int phase_travel[N_PHASES] = '{1, 255, 0, 2, 1, 5};
    int phase_mode[N_PHASES] = '{MODE_FREE, MODE_SEND_IDLE, MODE_RECV_STALL, MODE_BOTH,
                                 MODE_SEND_IDLE, MODE_RECV_STALL};
    int phase_items[N_PHASES] = '{400, 250, 250, 400, 300, 400};

    // Shadow state of the dispatcher; index 0 is car A and index 1 is car B.
    logic [CAR_FLOOR_W-1:0] car_at[2];
    logic                   car_up[2];
    logic [CAR_FLOOR_W-1:0] car_dest[2];
    logic [TICK_W-1:0]      car_ticks[2];
    logic [FIELD_W-1:0]     car_calls[2];
    logic [FIELD_W-1:0]     hall_up;
    logic [FIELD_W-1:0]     hall_dn;
    logic [TICK_W-1:0]      travel_ticks;

    two_car_elevator_dispatch #(
        .FLOORS(FLOORS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_rsp  (o_out_rsp),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    function automatic logic [FIELD_W-1:0] scan_car(input int k, input logic [FIELD_W-1:0] skip);
        int c;
        int f;
        logic [FIELD_W-1:0] up;
        logic [FIELD_W-1:0] dn;
        logic [FIELD_W-1:0] cu;
        logic [FIELD_W-1:0] cd;
        logic [FIELD_W-1:0] got;
        c = int'(car_at[k]);
        up = hall_up & ~skip;
        dn = hall_dn & ~skip;
        cu = car_calls[k] | up;
        cd = car_calls[k] | dn;
        got = '0;
        if (car_up[k]) begin
            for (f = c + 1; f < FLOORS; f++) begin
                if (cu[f]) begin
                    if (got == 0) begin
                        car_dest[k] = CAR_FLOOR_W'(f);
                        car_up[k] = 1'b1;
                    end
                    got[f] = 1'b1;
                end
            end
            for (f = FLOORS - 1; f >= 0 && got == 0; f--) begin
                if (f != c && cd[f]) begin
                    car_dest[k] = CAR_FLOOR_W'(f);
                    car_up[k] = (f > c);
                    got[f] = 1'b1;
                end
            end
            for (f = 0; f < c && got == 0; f++) begin
                if (up[f]) begin
                    car_dest[k] = CAR_FLOOR_W'(f);
                    car_up[k] = 1'b0;
                    got[f] = 1'b1;
                end
            end
        end else begin
            for (f = c - 1; f >= 0; f--) begin
                if (cd[f]) begin
                    if (got == 0) begin
                        car_dest[k] = CAR_FLOOR_W'(f);
                        car_up[k] = 1'b0;
                    end
                    got[f] = 1'b1;
                end
            end
            for (f = 0; f < FLOORS && got == 0; f++) begin
                if (f != c && cu[f]) begin
                    car_dest[k] = CAR_FLOOR_W'(f);
                    car_up[k] = (f > c);
                    got[f] = 1'b1;
                end
            end
            for (f = FLOORS - 1; f > c && got == 0; f--) begin
                if (dn[f]) begin
                    car_dest[k] = CAR_FLOOR_W'(f);
                    car_up[k] = 1'b1;
                    got[f] = 1'b1;
                end
            end
        end
        return got;
    endfunction

    function automatic logic move_car(input int k);
        logic arrived;
        int f;
        arrived = 1'b0;
        if (car_ticks[k] == travel_ticks) begin
            f = int'(car_at[k]);
            if (car_dest[k] > f) begin
                f++;
                if (f == FLOORS - 1) car_up[k] = 1'b0;
            end else if (car_dest[k] < f) begin
                f--;
                if (f == 0) car_up[k] = 1'b1;
            end
            car_at[k] = CAR_FLOOR_W'(f);
            if (f == car_dest[k]) begin
                arrived = 1'b1;
                car_calls[k][f] = 1'b0;
                if (car_up[k]) hall_up[f] = 1'b0;
                else hall_dn[f] = 1'b0;
                if (f == FLOORS - 1) hall_dn[f] = 1'b0;
                else if (f == 0) hall_up[f] = 1'b0;
            end
            car_ticks[k] = '0;
        end
        car_ticks[k] = car_ticks[k] + 1'b1;
        return arrived;
    endfunction

    function automatic tced_pkg::t_rsp dispatch_tick(input tced_pkg::t_req r);
        tced_pkg::t_rsp s;
        logic [FIELD_W-1:0] claimed_by_a;
        hall_up = hall_up | r.hall_up_press;
        hall_dn = hall_dn | r.hall_down_press;
        car_calls[0] = car_calls[0] | r.car_a_press;
        car_calls[1] = car_calls[1] | r.car_b_press;
        claimed_by_a = scan_car(0, '0);
        void'(scan_car(1, claimed_by_a));
        s.car_a_arrived = move_car(0);
        s.car_b_arrived = move_car(1);
        s.car_a_floor = car_at[0];
        s.car_a_up = car_up[0];
        s.car_a_target = car_dest[0];
        s.car_b_floor = car_at[1];
        s.car_b_up = car_up[1];
        s.car_b_target = car_dest[1];
        s.hall_up_pending = hall_up;
        s.hall_down_pending = hall_dn;
        return s;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_press();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return '0;
        if (r < 88) return 16'h0001 << $urandom_range(0, FLOORS - 1);
        if (r < 95) return (16'h0001 << $urandom_range(0, FLOORS - 1))
                         | (16'h0001 << $urandom_range(0, FLOORS - 1));
        return FIELD_W'($urandom_range(0, 65535));
    endfunction

    task automatic push_req(input logic [FIELD_W-1:0] hu, input logic [FIELD_W-1:0] hd,
                            input logic [FIELD_W-1:0] ca, input logic [FIELD_W-1:0] cb);
        tced_pkg::t_req r;
        r.hall_up_press = hu;
        r.hall_down_press = hd;
        r.car_a_press = ca;
        r.car_b_press = cb;
        press_q.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic drain();
        while (press_q.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_travel(input int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value[TICK_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        travel_ticks = value[TICK_W-1:0];
    endtask

    task automatic set_mode(input int mode);
        case (mode)
            MODE_FREE: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            MODE_SEND_IDLE: begin
                send_idle_pct = 63;
                recv_stall_pct = 0;
            end
            MODE_RECV_STALL: begin
                send_idle_pct = 0;
                recv_stall_pct = 63;
            end
            default: begin
                send_idle_pct = 22;
                recv_stall_pct = 22;
            end
        endcase
    endtask

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            if (!in_valid || req_fire) begin
                if (press_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_req <= press_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : result_check
        tced_pkg::t_rsp want;
        req_fire <= rst_n && in_valid && !o_in_stall;
        if (rst_n && in_valid && !o_in_stall) status_q.push_back(dispatch_tick(in_req));
        if (rst_n && o_out_valid && !out_stall) begin
            if (status_q.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_out_rsp);
            end else begin
                want = status_q.pop_front();
                check_field("car_a_floor", FIELD_W'(want.car_a_floor),
                            FIELD_W'(o_out_rsp.car_a_floor));
                check_field("car_a_up", FIELD_W'(want.car_a_up),
                            FIELD_W'(o_out_rsp.car_a_up));
                check_field("car_a_target", FIELD_W'(want.car_a_target),
                            FIELD_W'(o_out_rsp.car_a_target));
                check_field("car_a_arrived", FIELD_W'(want.car_a_arrived),
                            FIELD_W'(o_out_rsp.car_a_arrived));
                check_field("car_b_floor", FIELD_W'(want.car_b_floor),
                            FIELD_W'(o_out_rsp.car_b_floor));
                check_field("car_b_up", FIELD_W'(want.car_b_up),
                            FIELD_W'(o_out_rsp.car_b_up));
                check_field("car_b_target", FIELD_W'(want.car_b_target),
                            FIELD_W'(o_out_rsp.car_b_target));
                check_field("car_b_arrived", FIELD_W'(want.car_b_arrived),
                            FIELD_W'(o_out_rsp.car_b_arrived));
                check_field("hall_up_pending", want.hall_up_pending,
                            o_out_rsp.hall_up_pending);
                check_field("hall_down_pending", want.hall_down_pending,
                            o_out_rsp.hall_down_pending);
            end
        end
    end

    initial begin
        int p;
        int n;
        for (int k = 0; k < 2; k++) begin
            car_at[k] = '0;
            car_up[k] = 1'b1;
            car_dest[k] = '0;
            car_ticks[k] = '0;
            car_calls[k] = '0;
        end
        hall_up = '0;
        hall_dn = '0;
        travel_ticks = tced_pkg::TRAVEL_TICKS_RESET;
        set_mode(MODE_FREE);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Two up calls ahead of both cars: car A claims them, so car B must look elsewhere.
        push_req('0, '0, '0, '0);
        push_req(16'h0030, '0, '0, '0);
        repeat (3) push_req('0, '0, '0, '0);
        // Up call on the top floor and down call on the ground floor.
        push_req(16'h8000, 16'h0001, '0, '0);
        push_req('0, '0, 16'h8000, 16'h0001);
        repeat (4) push_req('0, '0, '0, '0);
        push_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (4) push_req('0, '0, '0, '0);
        push_req('0, 16'h0100, '0, 16'h0008);
        repeat (3) push_req('0, '0, '0, '0);
        drain();

        for (p = 0; p < N_PHASES; p++) begin
            write_travel(phase_travel[p]);
            set_mode(phase_mode[p]);
            for (n = 0; n < phase_items[p]; n++)
                push_req(rand_press(), rand_press(), rand_press(), rand_press());
            drain();
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(12_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
